### hw/rtl/rau_pkg.sv
`timescale 1ns / 1ps
package rau_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] a_num;
        logic [30:0]        a_den;
        logic signed [31:0] b_num;
        logic [30:0]        b_den;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic               den_zero;
        logic               overflow;
    } out_item_t;

    // one classified request: magnitudes and sign of the unreduced pair
    typedef struct packed {
        logic [63:0] un;
        logic [63:0] ud;
        logic        nneg;
        logic        dneg;
    } job_t;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_MUL1,
        FS_MUL2,
        FS_SUM,
        FS_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_GCD,
        BS_DIVN,
        BS_DIVD,
        BS_FMT,
        BS_OUT
    } back_state_t;

endpackage

### hw/rtl/rau_front.sv
`timescale 1ns / 1ps
module rau_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rau_pkg::in_item_t  s_data,
    output logic               job_valid,
    input  logic               job_ready,
    output rau_pkg::job_t      job_data
);

    rau_pkg::front_state_t state_reg, state_next;
    rau_pkg::in_item_t     item_reg;
    logic signed [63:0]    p1_reg, p2_reg, p3_reg;
    logic signed [63:0]    n_reg, d_reg;
    logic signed [32:0]    m1a, m1b, m2a, m2b;
    logic signed [63:0]    n_next;

    // two multiplies per cycle: first pass n terms, second d and a_num*b_num
    always_comb begin
        m1a = 33'(item_reg.a_num);
        m1b = $signed({2'b00, item_reg.b_den});
        m2a = 33'(item_reg.b_num);
        m2b = $signed({2'b00, item_reg.a_den});
        if (state_reg == rau_pkg::FS_MUL2) begin
            m1a = $signed({2'b00, item_reg.a_den});
            m1b = (rau_pkg::op_t'(item_reg.kind) == rau_pkg::OP_DIV) ?
                  33'(item_reg.b_num) : $signed({2'b00, item_reg.b_den});
            m2a = 33'(item_reg.a_num);
            m2b = 33'(item_reg.b_num);
        end
    end

    always_comb begin
        unique case (rau_pkg::op_t'(item_reg.kind))
            rau_pkg::OP_ADD: n_next = p1_reg + p2_reg;
            rau_pkg::OP_SUB: n_next = p1_reg - p2_reg;
            rau_pkg::OP_MUL: n_next = p3_reg;
            rau_pkg::OP_DIV: n_next = p1_reg;
            default:         n_next = p1_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rau_pkg::FS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == rau_pkg::FS_IDLE && s_valid) begin
            item_reg <= s_data;
        end
        if (state_reg == rau_pkg::FS_MUL1) begin
            p1_reg <= 64'(m1a * m1b);
            p2_reg <= 64'(m2a * m2b);
        end
        if (state_reg == rau_pkg::FS_MUL2) begin
            d_reg  <= 64'(m1a * m1b);
            p3_reg <= 64'(m2a * m2b);
        end
        if (state_reg == rau_pkg::FS_SUM) begin
            n_reg <= n_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        job_valid  = 1'b0;
        unique case (state_reg)
            rau_pkg::FS_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) state_next = rau_pkg::FS_MUL1;
            end
            rau_pkg::FS_MUL1: state_next = rau_pkg::FS_MUL2;
            rau_pkg::FS_MUL2: state_next = rau_pkg::FS_SUM;
            rau_pkg::FS_SUM:  state_next = rau_pkg::FS_PUSH;
            rau_pkg::FS_PUSH: begin
                job_valid = 1'b1;
                if (job_ready) state_next = rau_pkg::FS_IDLE;
            end
            default: state_next = rau_pkg::FS_IDLE;
        endcase
    end

    assign job_data.nneg = n_reg[63];
    assign job_data.dneg = d_reg[63];
    assign job_data.un   = n_reg[63] ? (64'd0 - n_reg) : n_reg;
    assign job_data.ud   = d_reg[63] ? (64'd0 - d_reg) : d_reg;

    a_push_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid && !job_ready |=> job_valid && $stable(n_reg) && $stable(d_reg))
        else $error("front job changed while stalled");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == rau_pkg::FS_IDLE)
        else $error("front accepted while busy");
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rau_pkg::FS_MUL1 |=> state_reg == rau_pkg::FS_MUL2)
        else $error("front sequence broken");

endmodule

### hw/rtl/rau_fifo.sv
`timescale 1ns / 1ps
module rau_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  rau_pkg::job_t  wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output rau_pkg::job_t  rd_data
);

    rau_pkg::job_t slot_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;
    logic          wr_fire, rd_fire;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = slot_reg[rp_reg];
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr_fire) wp_reg <= !wp_reg;
            if (rd_fire) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr_fire) - 2'(rd_fire);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_fire) slot_reg[wp_reg] <= wr_data;
    end

    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3)
        else $error("queue count out of range");

endmodule

### hw/rtl/rau_back.sv
`timescale 1ns / 1ps
module rau_back #(
    parameter int WORD_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               job_valid,
    output logic               job_ready,
    input  rau_pkg::job_t      job_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rau_pkg::out_item_t m_data
);

    localparam int CW = 6;

    rau_pkg::back_state_t state_reg, state_next;
    logic [63:0]   un_reg, ud_reg, x_reg, y_reg;
    logic [63:0]   rem_reg;
    logic [62:0]   quo_reg;
    logic [CW-1:0] bit_reg;
    logic          nneg_reg, dneg_reg;
    logic [64:0]   trial;
    logic [63:0]   dvd;
    rau_pkg::out_item_t res_reg;
    logic          neg_fin;
    logic [63:0]   tn;
    logic [63:0]   limit;
    logic          ovf;
    logic          gcd_step_done;

    // one restoring-division bit per cycle, shared by gcd remainders and both reductions
    assign dvd   = (state_reg == rau_pkg::BS_GCD) ? x_reg :
                   (state_reg == rau_pkg::BS_DIVN) ? un_reg : ud_reg;
    assign trial = {rem_reg, dvd[bit_reg]} - {1'b0, y_reg};
    assign gcd_step_done = bit_reg == CW'(0);

    assign limit   = 64'd1 << (WORD_BITS - 1);
    assign neg_fin = (un_reg != 64'd0) && (nneg_reg ^ (dneg_reg && ud_reg != 64'd0));
    assign tn      = neg_fin ? (64'd0 - un_reg) : un_reg;
    assign ovf     = (neg_fin ? (un_reg > limit) : (un_reg >= limit)) || (ud_reg >= limit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rau_pkg::BS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg) inside
            rau_pkg::BS_IDLE: begin
                if (job_valid) begin
                    un_reg   <= job_data.un;
                    ud_reg   <= job_data.ud;
                    nneg_reg <= job_data.nneg;
                    dneg_reg <= job_data.dneg;
                    x_reg    <= job_data.un;
                    y_reg    <= job_data.ud;
                    rem_reg  <= 64'd0;
                    bit_reg  <= CW'(63);
                end
            end
            rau_pkg::BS_GCD, rau_pkg::BS_DIVN, rau_pkg::BS_DIVD: begin
                if (state_reg == rau_pkg::BS_GCD && y_reg == 64'd0) begin
                    // gcd in x; divide un by it
                    y_reg   <= x_reg;
                    rem_reg <= 64'd0;
                    bit_reg <= CW'(63);
                end else if (gcd_step_done) begin
                    rem_reg <= 64'd0;
                    bit_reg <= CW'(63);
                    if (state_reg == rau_pkg::BS_GCD) begin
                        x_reg <= y_reg;
                        y_reg <= trial[64] ? {rem_reg[62:0], dvd[0]} : trial[63:0];
                    end else if (state_reg == rau_pkg::BS_DIVN) begin
                        un_reg <= {quo_reg, !trial[64]};
                    end else begin
                        ud_reg <= {quo_reg, !trial[64]};
                    end
                end else begin
                    if (!trial[64]) rem_reg <= trial[63:0];
                    else rem_reg <= {rem_reg[62:0], dvd[bit_reg]};
                    quo_reg <= {quo_reg[61:0], !trial[64]};
                    bit_reg <= bit_reg - CW'(1);
                end
            end
            rau_pkg::BS_FMT: begin
                res_reg.res_num  <= 32'($signed(tn[WORD_BITS-1:0]));
                res_reg.res_den  <= 31'(ud_reg[WORD_BITS-2:0]);
                res_reg.den_zero <= ud_reg == 64'd0;
                res_reg.overflow <= ovf;
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        job_ready  = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            rau_pkg::BS_IDLE: begin
                job_ready = 1'b1;
                if (job_valid) state_next = rau_pkg::BS_GCD;
            end
            rau_pkg::BS_GCD: begin
                if (y_reg == 64'd0)
                    state_next = (x_reg == 64'd0) ? rau_pkg::BS_FMT : rau_pkg::BS_DIVN;
            end
            rau_pkg::BS_DIVN: if (gcd_step_done) state_next = rau_pkg::BS_DIVD;
            rau_pkg::BS_DIVD: if (gcd_step_done) state_next = rau_pkg::BS_FMT;
            rau_pkg::BS_FMT:  state_next = rau_pkg::BS_OUT;
            rau_pkg::BS_OUT: begin
                m_valid = 1'b1;
                if (m_ready) state_next = rau_pkg::BS_IDLE;
            end
            default: state_next = rau_pkg::BS_IDLE;
        endcase
    end

    assign m_data = res_reg;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(res_reg))
        else $error("result changed while stalled");
    a_zero_den: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && res_reg.den_zero |-> res_reg.res_den == 31'd0)
        else $error("zero denominator flagged with nonzero denominator");
    a_div_after: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rau_pkg::BS_DIVN && gcd_step_done |=> state_reg == rau_pkg::BS_DIVD)
        else $error("reduction order broken");

endmodule

### hw/rtl/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// The front multiplies and sums the terms and the job passes the queue; then
// each Euclid remainder step is a restoring division, the loop is left, numerator
// and denominator are reduced by two more divisions and the result is formatted
// (both reductions are skipped when both parts are zero). Throughput: one request
// per back-end pass; front and back overlap through a two-entry queue.
// Reset: aresetn synchronous, active low; clears all control state.
module rational_arithmetic_unit #(
    parameter int WORD_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rau_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rau_pkg::out_item_t m_data
);

    logic          f_valid, f_ready, b_valid, b_ready;
    rau_pkg::job_t f_data, b_data;

    rau_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .job_valid(f_valid), .job_ready(f_ready), .job_data(f_data)
    );

    rau_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
    );

    rau_back #(.WORD_BITS(WORD_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(b_valid), .job_ready(b_ready), .job_data(b_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

endmodule

### sim/tb_rational_arithmetic_unit.sv
`timescale 1ns / 1ps
module tb_rational_arithmetic_unit;

    localparam int WB = 32;
    localparam int RANDOM_REQUESTS = 1530;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    rau_pkg::in_item_t   s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    rau_pkg::out_item_t  m_data;

    rau_pkg::out_item_t  pending_q[$];
    int         mismatches = 0;
    int         sent = 0;
    int         received = 0;
    int         den_zero_seen = 0;
    int         overflow_seen = 0;

    typedef struct {
        rau_pkg::in_item_t  req;
        bit                 fixed;
        rau_pkg::out_item_t res;
    } row_t;

    row_t rows[$];

    rational_arithmetic_unit #(.WORD_BITS(WB)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #1 aclk = ~aclk;

    initial begin
        #100000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
        longint unsigned r;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    function automatic rau_pkg::out_item_t reduce_fraction(rau_pkg::in_item_t req);
        longint an;
        longint ad;
        longint bn;
        longint bd;
        longint n;
        longint d;
        longint unsigned un;
        longint unsigned ud;
        longint unsigned g;
        longint unsigned lim;
        longint unsigned tn;
        bit nneg;
        bit dneg;
        rau_pkg::out_item_t res;
        an = longint'(req.a_num);
        ad = longint'({1'b0, req.a_den});
        bn = longint'(req.b_num);
        bd = longint'({1'b0, req.b_den});
        case (rau_pkg::op_t'(req.kind))
            rau_pkg::OP_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
            rau_pkg::OP_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
            rau_pkg::OP_MUL: begin n = an * bn; d = ad * bd; end
            default: begin n = an * bd; d = ad * bn; end
        endcase
        nneg = n < 0;
        dneg = d < 0;
        un = nneg ? -n : n;
        ud = dneg ? -d : d;
        g = euclid_gcd(un, ud);
        if (g != 0) begin
            un = un / g;
            ud = ud / g;
        end
        if (dneg && ud != 0) nneg = ~nneg;
        if (un == 0) nneg = 1'b0;
        lim = 64'd1 << (WB - 1);
        res.overflow = (nneg ? un > lim : un >= lim) || ud >= lim;
        tn = nneg ? -un : un;
        res.res_num = 32'(tn);
        res.res_den = 31'(ud);
        res.den_zero = ud == 0;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on response %0d: %s got %0d expected %0d", received, what, got, want);
        mismatches++;
    endtask

    function automatic rau_pkg::in_item_t make_req(rau_pkg::op_t op, int an, int unsigned ad,
                                                   int bn, int unsigned bd);
        rau_pkg::in_item_t r;
        r.kind = op;
        r.a_num = an;
        r.a_den = ad[30:0];
        r.b_num = bn;
        r.b_den = bd[30:0];
        return r;
    endfunction

    task automatic add_row(rau_pkg::in_item_t req, bit fixed = 0,
                           rau_pkg::out_item_t res = '0);
        row_t r;
        r.req = req;
        r.fixed = fixed;
        r.res = res;
        rows.push_back(r);
    endtask

    function automatic int rand_num();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 20) - 10;
            1: return $urandom_range(0, 2000) - 1000;
            2: return $urandom & 32'h0000_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic int unsigned rand_den();
        case ($urandom_range(0, 6))
            0: return 0;
            1: return $urandom_range(1, 12);
            2: return $urandom_range(1, 5000);
            3: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic send(rau_pkg::in_item_t req, bit fixed, rau_pkg::out_item_t res);
        int idle;
        idle = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
        if (idle > 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_q.push_back(fixed ? res : reduce_fraction(req));
        sent++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            rau_pkg::out_item_t want;
            received++;
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected response", 1, 0);
            end else begin
                want = pending_q.pop_front();
                if (m_data.res_num !== want.res_num)
                    report_mismatch("res_num", m_data.res_num, want.res_num);
                if (m_data.res_den !== want.res_den)
                    report_mismatch("res_den", m_data.res_den, want.res_den);
                if (m_data.den_zero !== want.den_zero)
                    report_mismatch("den_zero", m_data.den_zero, want.den_zero);
                if (m_data.overflow !== want.overflow)
                    report_mismatch("overflow", m_data.overflow, want.overflow);
                den_zero_seen += m_data.den_zero;
                overflow_seen += m_data.overflow;
            end
        end
    end

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
                m_ready <= stall == 0;
            end else if (stall > 0) begin
                stall--;
                m_ready <= stall == 0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        rau_pkg::in_item_t req;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_row(make_req(rau_pkg::OP_ADD, 1, 2, 1, 3), 1, '{32'sd5, 31'd6, 1'b0, 1'b0});
        add_row(make_req(rau_pkg::OP_SUB, 1, 2, 1, 2), 1, '{32'sd0, 31'd1, 1'b0, 1'b0});
        add_row(make_req(rau_pkg::OP_MUL, -2, 3, 3, 4), 1, '{-32'sd1, 31'd2, 1'b0, 1'b0});
        add_row(make_req(rau_pkg::OP_DIV, 1, 2, -1, 4), 1, '{-32'sd2, 31'd1, 1'b0, 1'b0});
        add_row(make_req(rau_pkg::OP_MUL, 0, 0, 5, 7), 1, '{32'sd0, 31'd0, 1'b1, 1'b0});
        add_row(make_req(rau_pkg::OP_ADD, 3, 0, 1, 5), 1, '{32'sd1, 31'd0, 1'b1, 1'b0});
        add_row(make_req(rau_pkg::OP_MUL, -3, 0, 1, 5), 1, '{-32'sd1, 31'd0, 1'b1, 1'b0});
        add_row(make_req(rau_pkg::OP_DIV, 1, 2, 0, 3), 1, '{32'sd1, 31'd0, 1'b1, 1'b0});
        add_row(make_req(rau_pkg::OP_DIV, 0, 2, 0, 3), 1, '{32'sd0, 31'd0, 1'b1, 1'b0});
        add_row(make_req(rau_pkg::OP_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1));
        add_row(make_req(rau_pkg::OP_MUL, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1));
        add_row(make_req(rau_pkg::OP_ADD, 32'h7fff_ffff, 1, 1, 1));
        add_row(make_req(rau_pkg::OP_SUB, 32'h8000_0000, 1, 1, 1));
        add_row(make_req(rau_pkg::OP_SUB, 32'h8000_0000, 1, 0, 1));
        add_row(make_req(rau_pkg::OP_MUL, 1, 32'h7fff_ffff, 1, 32'h7fff_ffff));
        add_row(make_req(rau_pkg::OP_DIV, 1, 32'h7fff_ffff, -1, 32'h7fff_ffff));
        add_row(make_req(rau_pkg::OP_DIV, 32'h8000_0000, 1, -1, 1));
        add_row(make_req(rau_pkg::OP_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                         32'h7fff_ffff));
        add_row(make_req(rau_pkg::OP_ADD, -1, 32'h7fff_ffff, -1, 32'h7fff_fffe));
        add_row(make_req(rau_pkg::OP_SUB, 32'h5555_5555, 32'h2aaa_aaaa, 32'haaaa_aaaa,
                         32'h5555_5555));

        foreach (rows[i]) send(rows[i].req, rows[i].fixed, rows[i].res);

        // hold until drained
        s_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);

        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            req.kind = 2'($urandom_range(0, 3));
            req.a_num = rand_num();
            req.a_den = 31'(rand_den());
            req.b_num = rand_num();
            req.b_den = 31'(rand_den());
            if (i % 400 == 399) begin
                s_valid <= 1'b0;
                while (pending_q.size() != 0) @(posedge aclk);
            end
            send(req, 0, '0);
        end

        s_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (2000) @(posedge aclk);
        $display("%0d requests sent, %0d responses checked", sent, received);
        $display("%0d zero-denominator and %0d overflow responses seen", den_zero_seen,
                 overflow_seen);
        if (mismatches == 0 && pending_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
